// File: hdl/level_gate_controller_with_commands_macros.svh
// assertion macros shared by the level gate controller rtl
`ifndef LEVEL_GATE_CONTROLLER_WITH_COMMANDS_MACROS_SVH
`define LEVEL_GATE_CONTROLLER_WITH_COMMANDS_MACROS_SVH

// plain check, sampled on the rising clock edge, off during reset
`define LGC_CHECK(label, prop, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (prop)) else $error(msg);

// same-cycle implication
`define LGC_IMPLY(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

// next-cycle implication
`define LGC_IMPLY_NEXT(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

`endif

// File: hdl/lgc_pkg.sv
// types and constants of the level gate controller
package lgc_pkg;

  localparam int MATCH_LEN = 5;
  localparam int IDX_W     = $clog2(MATCH_LEN);

  localparam logic [7:0]  CHAR_CR    = 8'h0D;
  localparam logic [7:0]  CHAR_LF    = 8'h0A;
  localparam logic [31:0] WORD_OPEN  = "OPEN";
  localparam logic [39:0] WORD_CLOSE = "CLOSE";
  localparam logic [31:0] WORD_AUTO  = "AUTO";

  localparam logic [15:0] SAFE_RESET   = 16'd2900;
  localparam logic [15:0] DANGER_RESET = 16'd1160;

  localparam logic CFG_SAFE   = 1'b0;
  localparam logic CFG_DANGER = 1'b1;

  localparam logic OP_BYTE = 1'b0;
  localparam logic OP_ECHO = 1'b1;

  localparam logic KIND_CMD  = 1'b0;
  localparam logic KIND_MEAS = 1'b1;

  localparam logic [1:0] ZONE_NONE   = 2'd0;
  localparam logic [1:0] ZONE_SAFE   = 2'd1;
  localparam logic [1:0] ZONE_ALARM  = 2'd2;
  localparam logic [1:0] ZONE_DANGER = 2'd3;

  localparam logic [1:0] MOTOR_NONE      = 2'd0;
  localparam logic [1:0] MOTOR_SEQ_OPEN  = 2'd1;
  localparam logic [1:0] MOTOR_SEQ_CLOSE = 2'd2;

  localparam logic [2:0] STAT_NONE       = 3'd0;
  localparam logic [2:0] STAT_OPEN       = 3'd1;
  localparam logic [2:0] STAT_CLOSE      = 3'd2;
  localparam logic [2:0] STAT_AUTO       = 3'd3;
  localparam logic [2:0] STAT_CLOSE_1ST  = 3'd4;
  localparam logic [2:0] STAT_UNKNOWN    = 3'd5;

  localparam logic [1:0] BUZZ_OFF    = 2'd0;
  localparam logic [1:0] BUZZ_ALARM  = 2'd1;
  localparam logic [1:0] BUZZ_DANGER = 2'd2;
  localparam logic [1:0] BUZZ_BEEP   = 2'd3;

  typedef enum logic [1:0] {
    CMD_OPEN,
    CMD_CLOSE,
    CMD_AUTO,
    CMD_UNKNOWN
  } cmd_t;

  typedef struct packed {
    logic line_done;
    cmd_t cmd;
  } line_stat_t;

endpackage

// File: hdl/lgc_line.sv
// serial line assembly and command word match
module lgc_line #(
  parameter int LINE_CAPACITY = 20
) (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                step_en,
  input  logic [7:0]          rx_byte,
  output lgc_pkg::line_stat_t stat
);

  localparam int LEN_W = $clog2(LINE_CAPACITY);

  logic [LEN_W-1:0] len_r, len_nxt;
  logic [7:0]       store_r [lgc_pkg::MATCH_LEN];
  logic             is_cr, is_lf, room, store_en;
  logic             m_open, m_close, m_auto;

  assign is_cr    = (rx_byte == lgc_pkg::CHAR_CR);
  assign is_lf    = (rx_byte == lgc_pkg::CHAR_LF);
  assign room     = (len_r < LEN_W'(LINE_CAPACITY - 1));
  // only the head of the line can ever match a command word
  assign store_en = step_en && !is_cr && !is_lf && room &&
                    (len_r < LEN_W'(lgc_pkg::MATCH_LEN));

  always_comb begin
    len_nxt = len_r;
    if (step_en && !is_cr) begin
      if (is_lf || !room) begin
        len_nxt = '0;
      end else begin
        len_nxt = len_r + LEN_W'(1);
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      len_r <= '0;
    end else begin
      len_r <= len_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (store_en) begin
      store_r[len_r[lgc_pkg::IDX_W-1:0]] <= rx_byte;
    end
  end

  assign m_open  = (len_r == LEN_W'(4)) &&
                   ({store_r[0], store_r[1], store_r[2], store_r[3]} == lgc_pkg::WORD_OPEN);
  assign m_close = (len_r == LEN_W'(5)) &&
                   ({store_r[0], store_r[1], store_r[2], store_r[3], store_r[4]}
                    == lgc_pkg::WORD_CLOSE);
  assign m_auto  = (len_r == LEN_W'(4)) &&
                   ({store_r[0], store_r[1], store_r[2], store_r[3]} == lgc_pkg::WORD_AUTO);

  always_comb begin
    stat.line_done = is_lf;
    priority if (m_open) begin
      stat.cmd = lgc_pkg::CMD_OPEN;
    end else if (m_close) begin
      stat.cmd = lgc_pkg::CMD_CLOSE;
    end else if (m_auto) begin
      stat.cmd = lgc_pkg::CMD_AUTO;
    end else begin
      stat.cmd = lgc_pkg::CMD_UNKNOWN;
    end
  end

endmodule

// File: hdl/lgc_zone.sv
// threshold registers and echo count zone classification
module lgc_zone (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        cfg_we,
  input  logic        cfg_index,
  input  logic [15:0] cfg_data,
  input  logic [15:0] echo_count,
  output logic [1:0]  zone
);

  logic [15:0] safe_r, danger_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      safe_r   <= lgc_pkg::SAFE_RESET;
      danger_r <= lgc_pkg::DANGER_RESET;
    end else if (cfg_we) begin
      unique case (cfg_index)
        lgc_pkg::CFG_SAFE:   safe_r   <= cfg_data;
        lgc_pkg::CFG_DANGER: danger_r <= cfg_data;
        default: ;
      endcase
    end
  end

  // safe test wins when thresholds overlap
  always_comb begin
    priority if (echo_count > safe_r) begin
      zone = lgc_pkg::ZONE_SAFE;
    end else if (echo_count <= danger_r) begin
      zone = lgc_pkg::ZONE_DANGER;
    end else begin
      zone = lgc_pkg::ZONE_ALARM;
    end
  end

endmodule

// File: hdl/level_gate_controller_with_commands.sv
// level gate controller: serial commands, echo zones and gate control
// a result passes the input register, then the output register; a blocked output holds
// it in the input register. throughput: one word per cycle while the output is not stalled,
// set by the combinational decision logic between the input register and the output register
// bytes that end no line (carriage return, ordinary text) give no result
// reset: synchronous active-low; gate closed, automatic mode, empty line,
// no zone yet, thresholds 2900 and 1160
module level_gate_controller_with_commands #(
  parameter int LINE_CAPACITY = 20
) (
  input  logic        clk,
  input  logic        rst_n,
  // input channel
  input  logic        in_valid,
  output logic        in_stall,
  input  logic        in_opcode,
  input  logic [7:0]  in_rx_byte,
  input  logic [15:0] in_echo_count,
  // result channel
  output logic        out_valid,
  input  logic        out_stall,
  output logic        out_kind,
  output logic [1:0]  out_zone,
  output logic        out_zone_changed,
  output logic        out_gate_is_open,
  output logic        out_manual_mode,
  output logic [1:0]  out_motor_action,
  output logic [2:0]  out_command_status,
  output logic [1:0]  out_buzzer_pattern,
  // configuration
  input  logic        cfg_we,
  input  logic        cfg_index,
  input  logic [15:0] cfg_data
);

`include "level_gate_controller_with_commands_macros.svh"

  // input register
  logic        s1_valid_r, s1_valid_nxt;
  logic        s1_opcode_r;
  logic [7:0]  s1_rx_r;
  logic [15:0] s1_echo_r;

  // control state
  logic       gate_r, gate_nxt;
  logic       manual_r, manual_nxt;
  logic [1:0] zone_r, zone_nxt;

  // output register
  logic       out_valid_r, out_valid_nxt;
  logic       kind_r, kind_nxt;
  logic [1:0] ozone_r, ozone_nxt;
  logic       changed_r, changed_nxt;
  logic [1:0] motor_r, motor_nxt;
  logic [2:0] status_r, status_nxt;
  logic [1:0] buzz_r, buzz_nxt;
  logic       gate_out_r, manual_out_r;

  lgc_pkg::line_stat_t lstat;
  logic [1:0]          meas_zone;
  logic                accept, has_result, out_free, s1_adv, step_byte;

  // check helpers
  logic res_step, cmd_shown, motor_run;

  // a word with no result leaves stage one even when the output is blocked
  assign has_result = (s1_opcode_r == lgc_pkg::OP_ECHO) || lstat.line_done;
  assign out_free   = !out_valid_r || !out_stall;
  assign s1_adv     = s1_valid_r && (!has_result || out_free);
  assign in_stall   = s1_valid_r && !s1_adv;
  assign accept     = in_valid && !in_stall;
  assign step_byte  = s1_adv && (s1_opcode_r == lgc_pkg::OP_BYTE);

  lgc_line #(
    .LINE_CAPACITY(LINE_CAPACITY)
  ) u_line (
    .clk    (clk),
    .rst_n  (rst_n),
    .step_en(step_byte),
    .rx_byte(s1_rx_r),
    .stat   (lstat)
  );

  lgc_zone u_zone (
    .clk       (clk),
    .rst_n     (rst_n),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data),
    .echo_count(s1_echo_r),
    .zone      (meas_zone)
  );

  // input register control
  always_comb begin
    s1_valid_nxt = s1_valid_r;
    if (accept) begin
      s1_valid_nxt = 1'b1;
    end else if (s1_adv) begin
      s1_valid_nxt = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_valid_r <= 1'b0;
    end else begin
      s1_valid_r <= s1_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      s1_opcode_r <= in_opcode;
      s1_rx_r     <= in_rx_byte;
      s1_echo_r   <= in_echo_count;
    end
  end

  // decision logic for the word in stage one
  always_comb begin
    gate_nxt    = gate_r;
    manual_nxt  = manual_r;
    zone_nxt    = zone_r;
    kind_nxt    = lgc_pkg::KIND_CMD;
    ozone_nxt   = zone_r;
    changed_nxt = 1'b0;
    motor_nxt   = lgc_pkg::MOTOR_NONE;
    status_nxt  = lgc_pkg::STAT_NONE;
    buzz_nxt    = lgc_pkg::BUZZ_BEEP;
    if (s1_opcode_r == lgc_pkg::OP_BYTE) begin
      // finished command line; zone reported unchanged
      unique case (lstat.cmd)
        lgc_pkg::CMD_OPEN: begin
          if (!gate_r) begin
            motor_nxt = lgc_pkg::MOTOR_SEQ_OPEN;
            gate_nxt  = 1'b1;
          end
          manual_nxt = 1'b1;
          status_nxt = lgc_pkg::STAT_OPEN;
        end
        lgc_pkg::CMD_CLOSE: begin
          if (gate_r) begin
            motor_nxt = lgc_pkg::MOTOR_SEQ_CLOSE;
            gate_nxt  = 1'b0;
          end
          manual_nxt = 1'b1;
          status_nxt = lgc_pkg::STAT_CLOSE;
        end
        lgc_pkg::CMD_AUTO: begin
          // automatic mode only with the gate closed
          if (!gate_r) begin
            manual_nxt = 1'b0;
            status_nxt = lgc_pkg::STAT_AUTO;
          end else begin
            status_nxt = lgc_pkg::STAT_CLOSE_1ST;
          end
        end
        lgc_pkg::CMD_UNKNOWN: status_nxt = lgc_pkg::STAT_UNKNOWN;
        default: status_nxt = lgc_pkg::STAT_UNKNOWN;
      endcase
    end else begin
      // measurement: classify, then act in automatic mode
      kind_nxt    = lgc_pkg::KIND_MEAS;
      ozone_nxt   = meas_zone;
      changed_nxt = (meas_zone != zone_r);
      zone_nxt    = meas_zone;
      priority if (meas_zone == lgc_pkg::ZONE_SAFE) begin
        buzz_nxt = lgc_pkg::BUZZ_OFF;
        if (!manual_r && gate_r) begin
          motor_nxt = lgc_pkg::MOTOR_SEQ_CLOSE;
          gate_nxt  = 1'b0;
        end
      end else if (meas_zone == lgc_pkg::ZONE_DANGER) begin
        buzz_nxt = lgc_pkg::BUZZ_DANGER;
        if (!manual_r && !gate_r) begin
          motor_nxt = lgc_pkg::MOTOR_SEQ_OPEN;
          gate_nxt  = 1'b1;
        end
      end else begin
        buzz_nxt = lgc_pkg::BUZZ_ALARM;
      end
    end
  end

  // state moves only when a word that yields a result leaves stage one
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      gate_r   <= 1'b0;
      manual_r <= 1'b0;
      zone_r   <= lgc_pkg::ZONE_NONE;
    end else if (s1_adv && has_result) begin
      gate_r   <= gate_nxt;
      manual_r <= manual_nxt;
      zone_r   <= zone_nxt;
    end
  end

  // output register
  always_comb begin
    out_valid_nxt = out_valid_r;
    if (s1_adv && has_result) begin
      out_valid_nxt = 1'b1;
    end else if (!out_stall) begin
      out_valid_nxt = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else begin
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (s1_adv && has_result) begin
      kind_r       <= kind_nxt;
      ozone_r      <= ozone_nxt;
      changed_r    <= changed_nxt;
      gate_out_r   <= gate_nxt;
      manual_out_r <= manual_nxt;
      motor_r      <= motor_nxt;
      status_r     <= status_nxt;
      buzz_r       <= buzz_nxt;
    end
  end

  assign out_valid          = out_valid_r;
  assign out_kind           = kind_r;
  assign out_zone           = ozone_r;
  assign out_zone_changed   = changed_r;
  assign out_gate_is_open   = gate_out_r;
  assign out_manual_mode    = manual_out_r;
  assign out_motor_action   = motor_r;
  assign out_command_status = status_r;
  assign out_buzzer_pattern = buzz_r;

  assign res_step  = s1_adv && has_result;
  assign cmd_shown = out_valid_r && (kind_r == lgc_pkg::KIND_CMD);
  assign motor_run = (motor_r != lgc_pkg::MOTOR_NONE);

  // a pending stalled result is never overwritten
  `LGC_CHECK(a_no_overwrite, !(out_valid_r && out_stall && res_step), "result lost")
  // an open sequence always leaves the gate open
  `LGC_IMPLY(a_open_seq, out_valid_r && (motor_r == lgc_pkg::MOTOR_SEQ_OPEN), gate_out_r, "gate shut")
  // command results beep and never flag a zone change
  `LGC_IMPLY(a_cmd_fields, cmd_shown, (buzz_r == lgc_pkg::BUZZ_BEEP) && !changed_r, "bad fields")
  // gate position changes exactly when the motor runs
  `LGC_IMPLY_NEXT(a_gate_motor, res_step, (gate_out_r != $past(gate_r)) == motor_run, "gate moved")

endmodule

// File: tb/sv/tb_level_gate_controller_with_commands.sv
// self-checking testbench of the level gate controller: directed table, then random phases
`timescale 1ns / 1ps

module tb_level_gate_controller_with_commands;

  localparam int LINE_CAP      = 20;
  // settle margin, also covering words that end no line
  localparam int SETTLE_CYCLES = 8;
  localparam int CYCLE_LIMIT   = 300000;
  localparam int PRINT_CAP     = 40;

  // one result word, laid out as the result ports
  typedef struct packed {
    logic       kind;
    logic [1:0] zone;
    logic       changed;
    logic       gate_pos;
    logic       manual;
    logic [1:0] motor;
    logic [2:0] status;
    logic [1:0] buzz;
  } res_t;

  // one input word, with an optional hand-typed expectation
  typedef struct {
    logic        opcode;
    logic [7:0]  rx_byte;
    logic [15:0] echo_count;
    bit          typed;
    res_t        want;
  } word_t;

  logic        clk = 1'b0;
  logic        rst_n;
  logic        in_valid;
  logic        in_stall;
  logic        in_opcode;
  logic [7:0]  in_rx_byte;
  logic [15:0] in_echo_count;
  logic        out_valid;
  logic        out_stall = 1'b0;
  logic        out_kind;
  logic [1:0]  out_zone;
  logic        out_zone_changed;
  logic        out_gate_is_open;
  logic        out_manual_mode;
  logic [1:0]  out_motor_action;
  logic [2:0]  out_command_status;
  logic [1:0]  out_buzzer_pattern;
  logic        cfg_we;
  logic        cfg_index;
  logic [15:0] cfg_data;

  level_gate_controller_with_commands #(
    .LINE_CAPACITY(LINE_CAP)
  ) u_top (
    .clk               (clk),
    .rst_n             (rst_n),
    .in_valid          (in_valid),
    .in_stall          (in_stall),
    .in_opcode         (in_opcode),
    .in_rx_byte        (in_rx_byte),
    .in_echo_count     (in_echo_count),
    .out_valid         (out_valid),
    .out_stall         (out_stall),
    .out_kind          (out_kind),
    .out_zone          (out_zone),
    .out_zone_changed  (out_zone_changed),
    .out_gate_is_open  (out_gate_is_open),
    .out_manual_mode   (out_manual_mode),
    .out_motor_action  (out_motor_action),
    .out_command_status(out_command_status),
    .out_buzzer_pattern(out_buzzer_pattern),
    .cfg_we            (cfg_we),
    .cfg_index         (cfg_index),
    .cfg_data          (cfg_data)
  );

  // 12 ns period
  always begin
    #6 clk = 1'b1;
    #6 clk = 1'b0;
  end

  // shadow of the controller: thresholds, line buffer, gate, mode, zone
  logic [15:0] safe_thr    = lgc_pkg::SAFE_RESET;
  logic [15:0] danger_thr  = lgc_pkg::DANGER_RESET;
  logic [7:0]  line_buf [LINE_CAP];
  int          line_len    = 0;
  logic        gate_shadow = 1'b0;
  logic        manual      = 1'b0;
  logic [1:0]  last_zone   = lgc_pkg::ZONE_NONE;

  word_t words_in_flight[$];   // driven, not yet accepted
  res_t  pending_results[$];   // expected, not yet seen on the output
  word_t script[$];            // words queued for the driver

  int unsigned cycle_count = 0;
  int unsigned error_count = 0;
  bit          calm = 1'b0;    // no idling on either side while set

  string cmd_words[3] = '{"OPEN", "CLOSE", "AUTO"};

  // line compare: same length, same bytes, text right-aligned in the vector
  function automatic bit line_matches(logic [39:0] text, int n);
    if (line_len != n) return 1'b0;
    for (int i = 0; i < n; i++)
      if (line_buf[i] != text[8*(n-1-i) +: 8]) return 1'b0;
    return 1'b1;
  endfunction

  // advance the shadow by one accepted word, give back its result if any
  task automatic predict_gate_result(input word_t w, output bit has, output res_t r);
    logic [1:0] zone_now;
    logic [1:0] motor;
    logic [2:0] status;
    logic [1:0] buzz;
    logic       changed;
    has   = 1'b0;
    r     = '0;
    motor = lgc_pkg::MOTOR_NONE;
    if (w.opcode == lgc_pkg::OP_BYTE) begin
      if (w.rx_byte == lgc_pkg::CHAR_CR) begin
        // carriage return is dropped
      end else if (w.rx_byte != lgc_pkg::CHAR_LF) begin
        // append, or wrap to an empty line when full
        if (line_len < LINE_CAP - 1) begin
          line_buf[line_len] = w.rx_byte;
          line_len++;
        end else begin
          line_len = 0;
        end
      end else begin
        if (line_matches(40'(lgc_pkg::WORD_OPEN), 4)) begin
          if (!gate_shadow) begin
            motor       = lgc_pkg::MOTOR_SEQ_OPEN;
            gate_shadow = 1'b1;
          end
          manual = 1'b1;
          status = lgc_pkg::STAT_OPEN;
        end else if (line_matches(lgc_pkg::WORD_CLOSE, 5)) begin
          if (gate_shadow) begin
            motor       = lgc_pkg::MOTOR_SEQ_CLOSE;
            gate_shadow = 1'b0;
          end
          manual = 1'b1;
          status = lgc_pkg::STAT_CLOSE;
        end else if (line_matches(40'(lgc_pkg::WORD_AUTO), 4)) begin
          // automatic mode is refused while the gate is open
          if (!gate_shadow) begin
            manual = 1'b0;
            status = lgc_pkg::STAT_AUTO;
          end else begin
            status = lgc_pkg::STAT_CLOSE_1ST;
          end
        end else begin
          status = lgc_pkg::STAT_UNKNOWN;
        end
        line_len = 0;
        r   = res_t'{lgc_pkg::KIND_CMD, last_zone, 1'b0, gate_shadow, manual, motor, status,
                     lgc_pkg::BUZZ_BEEP};
        has = 1'b1;
      end
    end else begin
      // safe test first, so it wins when thresholds overlap
      if (w.echo_count > safe_thr) zone_now = lgc_pkg::ZONE_SAFE;
      else if (w.echo_count <= danger_thr) zone_now = lgc_pkg::ZONE_DANGER;
      else zone_now = lgc_pkg::ZONE_ALARM;
      changed   = (zone_now != last_zone);
      last_zone = zone_now;
      if (zone_now == lgc_pkg::ZONE_SAFE) begin
        buzz = lgc_pkg::BUZZ_OFF;
        if (!manual && gate_shadow) begin
          motor       = lgc_pkg::MOTOR_SEQ_CLOSE;
          gate_shadow = 1'b0;
        end
      end else if (zone_now == lgc_pkg::ZONE_DANGER) begin
        buzz = lgc_pkg::BUZZ_DANGER;
        if (!manual && !gate_shadow) begin
          motor       = lgc_pkg::MOTOR_SEQ_OPEN;
          gate_shadow = 1'b1;
        end
      end else begin
        buzz = lgc_pkg::BUZZ_ALARM;
      end
      r   = res_t'{lgc_pkg::KIND_MEAS, zone_now, changed, gate_shadow, manual, motor,
                   lgc_pkg::STAT_NONE, buzz};
      has = 1'b1;
    end
  endtask

  task automatic report_mismatch(string what, logic [31:0] got, logic [31:0] want);
    error_count++;
    if (error_count <= PRINT_CAP)
      $display("mismatch in %s: got %0d, want %0d (cycle %0d)", what, got, want, cycle_count);
  endtask

  task automatic check_field(string what, logic [31:0] got, logic [31:0] want);
    if (got !== want) report_mismatch(what, got, want);
  endtask

  // scoreboard: output side first, then predict the word accepted at this edge
  always @(posedge clk) begin
    word_t w;
    res_t  want;
    res_t  r;
    bit    has;
    if (rst_n) begin
      if (out_valid && !out_stall) begin
        if (pending_results.size() == 0) begin
          report_mismatch("unexpected result", 32'd1, 32'd0);
        end else begin
          want = pending_results.pop_front();
          check_field("kind", 32'(out_kind), 32'(want.kind));
          check_field("zone", 32'(out_zone), 32'(want.zone));
          check_field("zone_changed", 32'(out_zone_changed), 32'(want.changed));
          check_field("gate_is_open", 32'(out_gate_is_open), 32'(want.gate_pos));
          check_field("manual_mode", 32'(out_manual_mode), 32'(want.manual));
          check_field("motor_action", 32'(out_motor_action), 32'(want.motor));
          check_field("command_status", 32'(out_command_status), 32'(want.status));
          check_field("buzzer_pattern", 32'(out_buzzer_pattern), 32'(want.buzz));
        end
      end
      if (in_valid && !in_stall && words_in_flight.size() != 0) begin
        w = words_in_flight.pop_front();
        predict_gate_result(w, has, r);
        // hand-typed rows replace the prediction
        if (has) pending_results.push_back(w.typed ? w.want : r);
      end
    end
  end

  // receiver stalls about a third of the cycles
  always @(posedge clk)
    out_stall <= !calm && ($urandom_range(0, 99) < 34);

  // watchdog
  always @(posedge clk) begin
    cycle_count++;
    if (cycle_count >= CYCLE_LIMIT) begin
      $display("[level_gate_controller_with_commands] ERROR");
      $finish;
    end
  end

  function automatic word_t byte_word(logic [7:0] b);
    word_t w;
    w = '{opcode: lgc_pkg::OP_BYTE, rx_byte: b, echo_count: 16'($urandom_range(0, 65535)),
          typed: 1'b0, want: '0};
    return w;
  endfunction

  function automatic word_t echo_word(logic [15:0] c);
    word_t w;
    w = '{opcode: lgc_pkg::OP_ECHO, rx_byte: 8'($urandom_range(0, 255)), echo_count: c,
          typed: 1'b0, want: '0};
    return w;
  endfunction

  function automatic word_t with_result(word_t w, res_t r);
    word_t t;
    t       = w;
    t.typed = 1'b1;
    t.want  = r;
    return t;
  endfunction

  task automatic queue_text(string s);
    for (int i = 0; i < s.len(); i++) script.push_back(byte_word(s[i]));
  endtask

  // echo count biased to the extremes and to both thresholds
  function automatic logic [15:0] rand_echo();
    logic [15:0] c;
    case ($urandom_range(0, 7))
      0: c = 16'h0000;
      1: c = 16'hFFFF;
      2: c = safe_thr - 16'd1 + 16'($urandom_range(0, 2));
      3: c = danger_thr - 16'd1 + 16'($urandom_range(0, 2));
      default: c = 16'($urandom_range(0, 65535));
    endcase
    return c;
  endfunction

  // mostly real commands, some mangled, noise and overflowing lines
  task automatic queue_random_line();
    int          k;
    int          n;
    int          pos;
    string       s;
    logic [7:0]  b;
    k = $urandom_range(0, 9);
    s = cmd_words[$urandom_range(0, 2)];
    case (k)
      6: begin
        // one character replaced
        pos = $urandom_range(0, s.len() - 1);
        for (int i = 0; i < s.len(); i++) begin
          b = (i == pos) ? 8'($urandom_range(0, 255)) : s[i];
          script.push_back(byte_word(b));
        end
      end
      7: begin
        // raw noise, may contain its own line ends
        n = $urandom_range(0, 8);
        repeat (n) script.push_back(byte_word(8'($urandom_range(0, 255))));
      end
      8: begin
        // overflow, then maybe a command in the fresh line
        n = $urandom_range(LINE_CAP - 1, LINE_CAP + 4);
        repeat (n) begin
          do b = 8'($urandom_range(0, 255)); while (b == lgc_pkg::CHAR_LF);
          script.push_back(byte_word(b));
        end
        if ($urandom_range(0, 1)) queue_text(s);
      end
      9: begin
        // one character too many or too few
        if ($urandom_range(0, 1)) begin
          queue_text(s);
          script.push_back(byte_word(8'($urandom_range(0, 255))));
        end else begin
          queue_text(s.substr(0, s.len() - 2));
        end
      end
      default: queue_text(s);
    endcase
    if ($urandom_range(0, 1)) script.push_back(byte_word(lgc_pkg::CHAR_CR));
    script.push_back(byte_word(lgc_pkg::CHAR_LF));
  endtask

  task automatic queue_random_mix(int count);
    while (script.size() < count) begin
      if ($urandom_range(0, 99) < 40) script.push_back(echo_word(rand_echo()));
      else queue_random_line();
    end
  endtask

  // drive one word and hold it until the block takes it
  task automatic send_word(word_t w);
    if (!calm && $urandom_range(0, 99) < 34) begin
      in_valid <= 1'b0;
      do @(posedge clk); while ($urandom_range(0, 99) < 34);
    end
    in_valid      <= 1'b1;
    in_opcode     <= w.opcode;
    in_rx_byte    <= w.rx_byte;
    in_echo_count <= w.echo_count;
    words_in_flight.push_back(w);
    do @(posedge clk); while (in_stall);
  endtask

  task automatic run_script();
    foreach (script[i]) send_word(script[i]);
    script.delete();
  endtask

  // sender quiet until every result is back, then let the pipe settle
  task automatic wait_idle();
    in_valid <= 1'b0;
    while (words_in_flight.size() != 0 || pending_results.size() != 0) @(negedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  // both thresholds in two back-to-back writes
  task automatic set_thresholds(logic [15:0] safe_val, logic [15:0] danger_val);
    cfg_we    <= 1'b1;
    cfg_index <= lgc_pkg::CFG_SAFE;
    cfg_data  <= safe_val;
    @(posedge clk);
    cfg_index <= lgc_pkg::CFG_DANGER;
    cfg_data  <= danger_val;
    @(posedge clk);
    cfg_we     <= 1'b0;
    safe_thr   = safe_val;
    danger_thr = danger_val;
  endtask

  initial begin
    logic [15:0] safe_val;
    logic [15:0] danger_val;
    rst_n         <= 1'b0;
    in_valid      <= 1'b0;
    in_opcode     <= lgc_pkg::OP_BYTE;
    in_rx_byte    <= 8'h00;
    in_echo_count <= 16'h0000;
    cfg_we        <= 1'b0;
    cfg_index     <= lgc_pkg::CFG_SAFE;
    cfg_data      <= 16'h0000;
    repeat (5) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // directed table at reset thresholds
    // lowest count: danger, automatic mode opens the closed gate
    script.push_back(with_result(echo_word(16'h0000),
      res_t'{lgc_pkg::KIND_MEAS, lgc_pkg::ZONE_DANGER, 1'b1, 1'b1, 1'b0,
             lgc_pkg::MOTOR_SEQ_OPEN, lgc_pkg::STAT_NONE, lgc_pkg::BUZZ_DANGER}));
    // highest count: safe, automatic mode closes it again
    script.push_back(with_result(echo_word(16'hFFFF),
      res_t'{lgc_pkg::KIND_MEAS, lgc_pkg::ZONE_SAFE, 1'b1, 1'b0, 1'b0,
             lgc_pkg::MOTOR_SEQ_CLOSE, lgc_pkg::STAT_NONE, lgc_pkg::BUZZ_OFF}));
    // empty line is unknown
    script.push_back(with_result(byte_word(lgc_pkg::CHAR_LF),
      res_t'{lgc_pkg::KIND_CMD, lgc_pkg::ZONE_SAFE, 1'b0, 1'b0, 1'b0,
             lgc_pkg::MOTOR_NONE, lgc_pkg::STAT_UNKNOWN, lgc_pkg::BUZZ_BEEP}));
    // count equal to the safe threshold is alarm
    script.push_back(echo_word(lgc_pkg::SAFE_RESET));
    queue_text("OPEN");
    script.push_back(with_result(byte_word(lgc_pkg::CHAR_LF),
      res_t'{lgc_pkg::KIND_CMD, lgc_pkg::ZONE_ALARM, 1'b0, 1'b1, 1'b1,
             lgc_pkg::MOTOR_SEQ_OPEN, lgc_pkg::STAT_OPEN, lgc_pkg::BUZZ_BEEP}));
    // count equal to the danger threshold, manual mode leaves the gate alone
    script.push_back(echo_word(lgc_pkg::DANGER_RESET));
    // auto refused while open
    queue_text("AUTO");
    script.push_back(with_result(byte_word(lgc_pkg::CHAR_LF),
      res_t'{lgc_pkg::KIND_CMD, lgc_pkg::ZONE_DANGER, 1'b0, 1'b1, 1'b1,
             lgc_pkg::MOTOR_NONE, lgc_pkg::STAT_CLOSE_1ST, lgc_pkg::BUZZ_BEEP}));
    // carriage return inside the line is dropped
    queue_text("CLOSE");
    script.push_back(byte_word(lgc_pkg::CHAR_CR));
    script.push_back(with_result(byte_word(lgc_pkg::CHAR_LF),
      res_t'{lgc_pkg::KIND_CMD, lgc_pkg::ZONE_DANGER, 1'b0, 1'b0, 1'b1,
             lgc_pkg::MOTOR_SEQ_CLOSE, lgc_pkg::STAT_CLOSE, lgc_pkg::BUZZ_BEEP}));
    queue_text("AUTO");
    script.push_back(with_result(byte_word(lgc_pkg::CHAR_LF),
      res_t'{lgc_pkg::KIND_CMD, lgc_pkg::ZONE_DANGER, 1'b0, 1'b0, 1'b0,
             lgc_pkg::MOTOR_NONE, lgc_pkg::STAT_AUTO, lgc_pkg::BUZZ_BEEP}));
    run_script();

    // random phases, each at its own threshold setting
    for (int p = 0; p < 7; p++) begin
      wait_idle();
      case (p)
        0: begin safe_val = lgc_pkg::SAFE_RESET; danger_val = lgc_pkg::DANGER_RESET; end
        1: begin
          safe_val   = 16'($urandom_range(1200, 5000));
          danger_val = 16'($urandom_range(0, safe_val));
        end
        2: begin safe_val = 16'h0000; danger_val = 16'h0000; end
        3: begin safe_val = 16'hFFFF; danger_val = 16'hFFFF; end
        4: begin safe_val = 16'h0000; danger_val = 16'hFFFF; end   // overlap, safe wins
        5: begin safe_val = 16'hFFFF; danger_val = 16'h0000; end
        default: begin
          safe_val   = 16'($urandom_range(0, 65535));
          danger_val = 16'($urandom_range(0, 65535));
        end
      endcase
      set_thresholds(safe_val, danger_val);
      // one phase runs with no idling at all
      calm = (p == 3);
      queue_random_mix(44);
      run_script();
      // sender pause until everything has come back
      wait_idle();
      queue_random_mix(44);
      run_script();
    end
    calm = 1'b0;

    wait_idle();
    if (error_count == 0) begin
      $display("[level_gate_controller_with_commands] OK");
    end else begin
      $display("[level_gate_controller_with_commands] ERROR");
    end
    $finish;
  end

endmodule

// File: level_gate_controller_with_commands.f
+incdir+hdl
hdl/lgc_pkg.sv
hdl/lgc_line.sv
hdl/lgc_zone.sv
hdl/level_gate_controller_with_commands.sv
tb/sv/tb_level_gate_controller_with_commands.sv
